@@ rtl/pis_pkg.sv @@
// shared types and constants of the palette integer scaler
`timescale 1ns / 1ps
`default_nettype none

package pis_pkg;

	localparam int CH_W    = 8;
	localparam int IDX_W   = 8;
	localparam int DIM_W   = 13;
	localparam int COORD_W = 12;
	localparam int SCALE_W = 5;

	localparam logic [DIM_W-1:0] SCREEN_LIMIT = 13'd4096;

	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_PIXEL     = 1'b1;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [SCALE_W-1:0] scale;
	} geom_t;

	typedef struct packed {
		logic             wr;
		logic             rd;
		logic [IDX_W-1:0] index;
		rgb_t             data;
	} pal_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SCALE_W-1:0] count;
	} run_t;

endpackage

`default_nettype wire

@@ rtl/palette_integer_scaler_top.sv @@
// palette lookup and integer upscaler, top level
//
// channel   direction  handshake            payload
// request   in         in_valid / in_stall  operation, color_index, red, green, blue
// pixel     out        out_valid / out_stall out_red, out_green, out_blue, out_x, out_y,
//                                           last_of_run
// config    in         apb write / read     screen_width, screen_height
//
// a pixel holds the output register for each visible copy, up to the scale, so the copy
// count of the run, together with out_stall, sets the request rate
// a visible pixel request passes the stage register run_s1, with the palette read beside it, then the output register
// after reset the table reads as a grey ramp through per-entry flags, no clearing pass
// a register write holds off requests in the cycle after it while the geometry settles
`timescale 1ns / 1ps
`default_nettype none

module palette_integer_scaler_top #(
	parameter int SRC_WIDTH    = 320,
	parameter int SRC_HEIGHT   = 200,
	parameter int PALETTE_SIZE = 256,
	parameter int MAX_SCALE    = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [2:0]                  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         operation,
	input  wire  [pis_pkg::IDX_W-1:0]   color_index,
	input  wire  [pis_pkg::CH_W-1:0]    red,
	input  wire  [pis_pkg::CH_W-1:0]    green,
	input  wire  [pis_pkg::CH_W-1:0]    blue,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [pis_pkg::CH_W-1:0]    out_red,
	output logic [pis_pkg::CH_W-1:0]    out_green,
	output logic [pis_pkg::CH_W-1:0]    out_blue,
	output logic [pis_pkg::COORD_W-1:0] out_x,
	output logic [pis_pkg::COORD_W-1:0] out_y,
	output logic                        last_of_run
);
	import pis_pkg::*;

	localparam int COL_W = $clog2(SRC_WIDTH + 1);
	localparam int ROW_W = $clog2(SRC_HEIGHT * MAX_SCALE + 1);
	localparam int POS_W = $clog2(4096 + (SRC_WIDTH + SRC_HEIGHT) * MAX_SCALE) + 1;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             cfg_wr;
	logic             geom_pend_q;
	geom_t            geom;
	pal_req_t         pal_req;
	rgb_t             color;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_inc;
	logic [POS_W-1:0] row_inc;
	logic [POS_W-1:0] row_total;

	logic             in_accept;
	logic             is_pixel;
	logic [POS_W-1:0] ty_full;
	logic [POS_W-1:0] tx_base;
	logic [POS_W-1:0] tx_room;
	logic             visible;
	logic [SCALE_W-1:0] count;

	logic             s1_valid_s1;
	run_t             run_s1;
	logic             run_free;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd320;
			height_q <= 13'd200;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SCREEN_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_SCREEN_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCREEN_WIDTH:  prdata = 32'(width_q);
			REG_SCREEN_HEIGHT: prdata = 32'(height_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_pend_q <= 1'b1;
		end else begin
			geom_pend_q <= cfg_wr;
		end
	end

	pis_geometry #(
		.SRC_WIDTH  (SRC_WIDTH),
		.SRC_HEIGHT (SRC_HEIGHT),
		.MAX_SCALE  (MAX_SCALE)
	) u_geometry (
		.clk           (clk),
		.screen_width  (width_q),
		.screen_height (height_q),
		.geom          (geom)
	);

	// request side
	assign in_stall  = geom_pend_q || (s1_valid_s1 && !run_free);
	assign in_accept = in_valid && !in_stall;
	assign is_pixel  = operation == OP_PIXEL;

	assign pal_req.wr    = in_accept && (operation == OP_PAL_WRITE);
	assign pal_req.rd    = in_accept && is_pixel;
	assign pal_req.index = color_index;
	assign pal_req.data  = '{r: red, g: green, b: blue};

	pis_palette #(
		.PALETTE_SIZE (PALETTE_SIZE)
	) u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pal_req),
		.color  (color)
	);

	// placement of the copies
	assign ty_full = POS_W'(geom.top) + POS_W'(row_q);
	assign tx_base = POS_W'(geom.left) + POS_W'(col_q) * POS_W'(geom.scale);
	assign tx_room = POS_W'(geom.w) - tx_base;
	assign visible = (ty_full < POS_W'(geom.h)) && (tx_base < POS_W'(geom.w));
	assign count   = (tx_room < POS_W'(geom.scale)) ? tx_room[SCALE_W-1:0] : geom.scale;

	assign col_inc   = col_q + COL_W'(1);
	assign row_inc   = POS_W'(row_q) + POS_W'(1);
	assign row_total = POS_W'(SRC_HEIGHT) * POS_W'(geom.scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept && is_pixel) begin
			if (col_inc == COL_W'(SRC_WIDTH)) begin
				col_q <= '0;
				row_q <= (row_inc >= row_total) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!s1_valid_s1 || run_free) begin
			s1_valid_s1 <= in_accept && is_pixel && visible;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && is_pixel) begin
			run_s1.x     <= tx_base[COORD_W-1:0];
			run_s1.y     <= ty_full[COORD_W-1:0];
			run_s1.count <= count;
		end
	end

	pis_run u_run (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (s1_valid_s1),
		.run         (run_s1),
		.color       (color),
		.free        (run_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.out_x       (out_x),
		.out_y       (out_y),
		.last_of_run (last_of_run)
	);

	a_run_steps_right: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=>
			out_valid && out_x == $past(out_x) + COORD_W'(1) && out_y == $past(out_y))
		else $error("copy column did not advance within a run");

	a_cfg_holds_requests: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> in_stall)
		else $error("request taken before geometry settled");

	a_copy_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> DIM_W'(out_x) < geom.w && DIM_W'(out_y) < geom.h)
		else $error("copy placed outside the screen");

endmodule

`default_nettype wire

@@ rtl/pis_geometry.sv @@
// scale and centring origins derived from the screen size registers
`timescale 1ns / 1ps
`default_nettype none

module pis_geometry #(
	parameter int SRC_WIDTH  = 320,
	parameter int SRC_HEIGHT = 200,
	parameter int MAX_SCALE  = 8
) (
	input  wire                        clk,
	input  wire  [pis_pkg::DIM_W-1:0]  screen_width,
	input  wire  [pis_pkg::DIM_W-1:0]  screen_height,
	output pis_pkg::geom_t             geom
);
	import pis_pkg::*;

	localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
	localparam int D_W     = $clog2(SRC_MAX * MAX_SCALE + 4097) + 1;

	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [D_W-1:0]     w_ext;
	logic [D_W-1:0]     h_ext;
	logic [SCALE_W-1:0] scale;
	logic [D_W-1:0]     pic_w;
	logic [D_W-1:0]     pic_h;
	logic [D_W-1:0]     left;
	logic [D_W-1:0]     top;
	geom_t              geom_q;

	assign w_eff = (screen_width > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_width;
	assign h_eff = (screen_height > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_height;
	assign w_ext = D_W'(w_eff);
	assign h_ext = D_W'(h_eff);

	// largest scale whose picture fits both ways, else one
	always_comb begin
		scale = SCALE_W'(1);
		for (int s = 1; s <= MAX_SCALE; s++) begin
			if (D_W'(SRC_WIDTH * s) <= w_ext && D_W'(SRC_HEIGHT * s) <= h_ext) begin
				scale = SCALE_W'(s);
			end
		end
	end

	assign pic_w = D_W'(SRC_WIDTH) * D_W'(scale);
	assign pic_h = D_W'(SRC_HEIGHT) * D_W'(scale);
	assign left  = (w_ext > pic_w) ? ((w_ext - pic_w) >> 1) : '0;
	assign top   = (h_ext > pic_h) ? ((h_ext - pic_h) >> 1) : '0;

	always_ff @(posedge clk) begin
		geom_q.w     <= w_eff;
		geom_q.h     <= h_eff;
		geom_q.left  <= left[COORD_W-1:0];
		geom_q.top   <= top[COORD_W-1:0];
		geom_q.scale <= scale;
	end

	assign geom = geom_q;

endmodule

`default_nettype wire

@@ rtl/pis_palette.sv @@
// colour table memory with grey ramp entry flags
`timescale 1ns / 1ps
`default_nettype none

module pis_palette #(
	parameter int PALETTE_SIZE = 256
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pis_pkg::pal_req_t    req,
	output pis_pkg::rgb_t        color
);
	import pis_pkg::*;

	localparam int PA_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

	rgb_t                    mem [PALETTE_SIZE];
	logic [PALETTE_SIZE-1:0] vld_q;
	logic                    in_range;
	logic [PA_W-1:0]         addr;
	rgb_t                    mem_s1;
	logic                    vld_s1;
	logic                    black_s1;
	logic [IDX_W-1:0]        idx_s1;

	assign in_range = {1'b0, req.index} < (IDX_W + 1)'(PALETTE_SIZE);
	assign addr     = req.index[PA_W-1:0];

	always_ff @(posedge clk) begin
		if (req.wr && in_range) begin
			mem[addr] <= req.data;
		end
		if (req.rd) begin
			mem_s1 <= mem[addr];
		end
	end

	// entry never written reads as its grey ramp value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr && in_range) begin
			vld_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			vld_s1   <= vld_q[addr];
			black_s1 <= !in_range;
			idx_s1   <= req.index;
		end
	end

	always_comb begin
		if (black_s1) begin
			color = '0;
		end else if (vld_s1) begin
			color = mem_s1;
		end else begin
			color = '{r: idx_s1, g: idx_s1, b: idx_s1};
		end
	end

endmodule

`default_nettype wire

@@ rtl/pis_run.sv @@
// output register that emits one replicated copy per cycle while out_stall is low
`timescale 1ns / 1ps
`default_nettype none

module pis_run (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         load_valid,
	input  pis_pkg::run_t               run,
	input  pis_pkg::rgb_t               color,
	output logic                        free,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [pis_pkg::CH_W-1:0]    out_red,
	output logic [pis_pkg::CH_W-1:0]    out_green,
	output logic [pis_pkg::CH_W-1:0]    out_blue,
	output logic [pis_pkg::COORD_W-1:0] out_x,
	output logic [pis_pkg::COORD_W-1:0] out_y,
	output logic                        last_of_run
);
	import pis_pkg::*;

	logic               out_valid_q;
	rgb_t               rgb_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [SCALE_W-1:0] remain_q;
	logic               last;
	logic               load;

	assign last = remain_q == SCALE_W'(1);
	assign free = !out_valid_q || (!out_stall && last);
	assign load = load_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall && last) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rgb_q    <= color;
			x_q      <= run.x;
			y_q      <= run.y;
			remain_q <= run.count;
		end else if (out_valid_q && !out_stall) begin
			x_q      <= x_q + COORD_W'(1);
			remain_q <= remain_q - SCALE_W'(1);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = rgb_q.r;
	assign out_green   = rgb_q.g;
	assign out_blue    = rgb_q.b;
	assign out_x       = x_q;
	assign out_y       = y_q;
	assign last_of_run = last;

endmodule

`default_nettype wire
